>>> rtl/hms_pkg.sv
// types, constants and the seven-segment table for the hours-minutes-seconds clock
// no dependencies; imported by hms_seg_pair and the top level
`default_nettype none

package hms_pkg;

  // request operation codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  // time limits
  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] UNIT_MAX = 6'd59;
  localparam logic [4:0] HALF_DAY = 5'd12;

  // input request
  typedef struct packed {
    logic       operation;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } in_t;

  // display result
  typedef struct packed {
    logic [6:0] hour_tens_segments;
    logic [6:0] hour_ones_segments;
    logic [6:0] minute_tens_segments;
    logic [6:0] minute_ones_segments;
    logic [6:0] second_tens_segments;
    logic [6:0] second_ones_segments;
    logic       afternoon;
    logic       show_meridiem;
  } out_t;

  // digit to segments: bit0 top ... bit6 middle, blank for non-digits
  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hms_clock_seven_segment_driver_unit.sv
// Hours-minutes-seconds clock with seven-segment display output.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): each request is either
// a one-second tick or a load of a full time (out-of-range fields saturate to
// 23 or 59). The time registers update on the edge the request is accepted.
// Output channel (out_valid_o / out_ready_i / out_data_o): one result per
// request, showing the time after that request as six digit patterns plus
// the AM/PM flags. cfg_we_i / cfg_data_i write the 12-hour mode bit; write it
// only while no request is in flight.
// On acceptance the time registers load, then the segment decode register loads
// when the result stage is free, and the result becomes valid. Throughput: one
// request per cycle while the receiver takes results; with it stalled, new
// requests stop once both stages are full.
// Stall: the time registers act as the first stage and the decoded result as
// the second; with the receiver stalled one more request is taken before
// in_ready_o drops.
// Reset: time clears to 00:00:00, 12-hour mode on, both stages empty.
// depends on hms_pkg and hms_seg_pair
`default_nettype none

module hms_clock_seven_segment_driver_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hms_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hms_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_data_i
);
  import hms_pkg::*;

  logic       mode_q;
  logic [4:0] hour_q, hour_d;
  logic [5:0] minute_q, minute_d;
  logic [5:0] second_q, second_d;
  logic       s1_valid_q;
  logic       s1_mode_q;
  logic       out_valid_q;
  out_t       out_q, out_d;
  logic       in_fire;
  logic       s2_take;
  logic [4:0] shown_hour;
  logic [6:0] hour_tens, hour_ones, min_tens, min_ones, sec_tens, sec_ones;

  // handshake between stages
  assign s2_take    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_take;
  assign in_fire    = in_valid_i && in_ready_o;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // next time: saturating load or tick with carries
  always_comb begin
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    if (in_data_i.operation == OP_LOAD) begin
      hour_d   = (in_data_i.load_hour   > HOUR_MAX) ? HOUR_MAX : in_data_i.load_hour;
      minute_d = (in_data_i.load_minute > UNIT_MAX) ? UNIT_MAX : in_data_i.load_minute;
      second_d = (in_data_i.load_second > UNIT_MAX) ? UNIT_MAX : in_data_i.load_second;
    end else if (second_q >= UNIT_MAX) begin
      second_d = 6'd0;
      if (minute_q >= UNIT_MAX) begin
        minute_d = 6'd0;
        hour_d   = (hour_q >= HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
      end else begin
        minute_d = minute_q + 6'd1;
      end
    end else begin
      second_d = second_q + 6'd1;
    end
  end

  // time registers form the first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q     <= 5'd0;
      minute_q   <= 6'd0;
      second_q   <= 6'd0;
      s1_valid_q <= 1'b0;
      s1_mode_q  <= 1'b1;
    end else begin
      if (in_fire) begin
        hour_q    <= hour_d;
        minute_q  <= minute_d;
        second_q  <= second_d;
        s1_mode_q <= mode_q;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s2_take) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // displayed hour in 12-hour mode
  always_comb begin
    shown_hour = hour_q;
    if (s1_mode_q) begin
      if (hour_q > HALF_DAY) begin
        shown_hour = hour_q - HALF_DAY;
      end else if (hour_q == 5'd0) begin
        shown_hour = HALF_DAY;
      end
    end
  end

  // digit decoders
  hms_seg_pair u_hour (
    .value_i    ({1'b0, shown_hour}),
    .tens_seg_o (hour_tens),
    .ones_seg_o (hour_ones)
  );

  hms_seg_pair u_minute (
    .value_i    (minute_q),
    .tens_seg_o (min_tens),
    .ones_seg_o (min_ones)
  );

  hms_seg_pair u_second (
    .value_i    (second_q),
    .tens_seg_o (sec_tens),
    .ones_seg_o (sec_ones)
  );

  // result assembly
  always_comb begin
    out_d.hour_tens_segments   = hour_tens;
    out_d.hour_ones_segments   = hour_ones;
    out_d.minute_tens_segments = min_tens;
    out_d.minute_ones_segments = min_ones;
    out_d.second_tens_segments = sec_tens;
    out_d.second_ones_segments = sec_ones;
    out_d.afternoon            = (hour_q >= HALF_DAY);
    out_d.show_meridiem        = s1_mode_q;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // time stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hour_q <= HOUR_MAX) && (minute_q <= UNIT_MAX) && (second_q <= UNIT_MAX))
    else $error("time register out of range");

  // both stages full and receiver stalled blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("request accepted with both stages full");

  // tick at 59 seconds wraps seconds to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.operation == OP_TICK) && (second_q == UNIT_MAX))
      |=> (second_q == 6'd0))
    else $error("seconds did not wrap");

  // a tick below 59 seconds leaves hours and minutes alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.operation == OP_TICK) && (second_q != UNIT_MAX))
      |=> ($stable(hour_q) && $stable(minute_q)))
    else $error("carry without seconds wrap");

endmodule

`default_nettype wire

>>> rtl/hms_seg_pair.sv
// splits a value 0..59 into tens and ones digits and decodes both to segments
// depends on hms_pkg (seg_of)
`default_nettype none

module hms_seg_pair (
  input  logic [5:0] value_i,
  output logic [6:0] tens_seg_o,
  output logic [6:0] ones_seg_o
);
  import hms_pkg::*;

  logic [9:0] prod;
  logic [2:0] tens;
  logic [5:0] tens_x10;
  logic [5:0] ones_wide;

  // divide by ten as multiply by 13/128, exact for values below 60
  assign prod      = {4'd0, value_i} * 10'd13;
  assign tens      = prod[9:7];
  assign tens_x10  = {3'd0, tens} * 6'd10;
  assign ones_wide = value_i - tens_x10;

  // segment decode
  assign tens_seg_o = seg_of({1'b0, tens});
  assign ones_seg_o = seg_of(ones_wide[3:0]);

endmodule

`default_nettype wire
